FILE: rtl/pgrb_pkg.sv
// ----------------------------------------------------------------------------
// pgrb_pkg
// Shared constants and types of the projection grid resonance binner.
// ----------------------------------------------------------------------------
package pgrb_pkg;

    // Resonance percentage thresholds
    localparam int PCT_SCALE = 100;
    localparam int PCT_LOW   = 20;
    localparam int PCT_HIGH  = 60;

    // Dot product accumulator width (four 16x16 products, signed)
    localparam int ACC_W = 35;

    // Configuration register indexes
    localparam logic [2:0] REG_X_WEIGHT = 3'd0;
    localparam logic [2:0] REG_Y_WEIGHT = 3'd1;
    localparam logic [2:0] REG_X_SHIFT  = 3'd2;
    localparam logic [2:0] REG_Y_SHIFT  = 3'd3;
    localparam logic [2:0] REG_X_LOW    = 3'd4;
    localparam logic [2:0] REG_X_HIGH   = 3'd5;
    localparam logic [2:0] REG_Y_LOW    = 3'd6;
    localparam logic [2:0] REG_Y_HIGH   = 3'd7;

    // Input opcodes and result kinds
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;
    localparam logic KIND_STATE = 1'b0;
    localparam logic KIND_CELL  = 1'b1;

    // One result item
    typedef struct packed {
        logic               kind;
        logic [31:0]        echo_id;
        logic [2:0]         cell_col;
        logic [2:0]         cell_row;
        logic signed [31:0] proj_x;
        logic signed [31:0] proj_y;
        logic signed [2:0]  resonance;
        logic               last;
    } t_result;

endpackage

FILE: rtl/pgrb_ram.sv
// ----------------------------------------------------------------------------
// pgrb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pgrb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/projection_grid_resonance_binner_core.sv
// ----------------------------------------------------------------------------
// projection_grid_resonance_binner_core
// Projects state vectors onto two axes, bins them into a grid, classifies a
// resonance and keeps per-cell resonance sums; a finish item dumps averages.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: item_id, elem_0..3; tuser: opcode
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: echo_id..resonance; tuser: kind;
//                                             tlast: last
//  cfg      in   i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  Add item: the shared multiply-accumulate and the bit-per-cycle bin divider
//  run for each axis in turn before the result; an axis whose range is empty
//  skips its divide steps.
//  Finish item: a store read, an average and a transfer per cell, GRID*GRID cells.
//  One item at a time: s_axis_tready is high only when idle.
//  Reset clears the cell store valid bits at once; no clearing pass is needed.
//  A stalled result simply holds until m_axis_tready.
module projection_grid_resonance_binner_core
    import pgrb_pkg::*;
#(
    parameter int VEC_LEN = 4,
    parameter int GRID    = 5
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // item_id[31:0], elem_0..elem_3 (16 each)
    input  logic         s_axis_tuser,   // opcode
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // echo_id, cell_col, cell_row, proj_x,
                                         // proj_y, resonance, zero pad
    output logic         m_axis_tuser,   // kind
    output logic         m_axis_tlast,   // last
    // configuration writes
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data
);

    localparam int QW     = $clog2(GRID);
    localparam int NCELLS = GRID * GRID;
    localparam int CW     = $clog2(NCELLS);
    localparam int IW     = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
    localparam int NUM_W  = 33 + QW;
    localparam int KW     = (QW > 1) ? $clog2(QW) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MAC   = 4'd1;
    localparam logic [3:0] S_CLAMP = 4'd2;
    localparam logic [3:0] S_BSET  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_RES   = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_WR    = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_FRD   = 4'd9;
    localparam logic [3:0] S_FCALC = 4'd10;
    localparam logic [3:0] S_FOUT  = 4'd11;

    // configuration
    logic [63:0]        r_xw, r_yw;
    logic [5:0]         r_xsh, r_ysh;
    logic signed [31:0] r_xlo, r_xhi, r_ylo, r_yhi;

    // sequencer and datapath
    logic [3:0]              r_state;
    logic                    r_ax;
    logic [IW-1:0]           r_idx;
    logic [31:0]             r_id;
    logic signed [15:0]      r_elem [VEC_LEN];
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0]      r_v;
    logic signed [31:0]      r_px, r_py;
    logic [NUM_W-1:0]        r_num;
    logic [32:0]             r_den;
    logic [QW-1:0]           r_q;
    logic [KW-1:0]           r_k;
    logic [QW-1:0]           r_bx, r_by;
    logic signed [2:0]       r_res;
    logic [CW-1:0]           r_cell;
    logic [QW-1:0]           r_fcol, r_frow;
    logic [NCELLS-1:0]       r_valid;
    t_result                 r_out;
    logic                    r_ovalid;

    // store
    logic             ram_we;
    logic [63:0]      ram_wdata;
    logic [63:0]      ram_rdata;

    // axis selection
    logic [63:0]        ax_w;
    logic [5:0]         ax_sh;
    logic signed [31:0] ax_lo, ax_hi;

    assign ax_w  = r_ax ? r_yw  : r_xw;
    assign ax_sh = r_ax ? r_ysh : r_xsh;
    assign ax_lo = r_ax ? r_ylo : r_xlo;
    assign ax_hi = r_ax ? r_yhi : r_xhi;

    // shared multiply-accumulate
    logic signed [15:0]      mac_w;
    logic signed [31:0]      mac_p;
    logic signed [ACC_W-1:0] n_acc;

    assign mac_w = ax_w[16*r_idx +: 16];
    assign mac_p = mac_w * r_elem[r_idx];
    assign n_acc = r_acc + {{(ACC_W-32){mac_p[31]}}, mac_p};

    // shift toward zero and clamp
    logic [ACC_W-1:0]      sh_abs, sh_mag;
    logic signed [ACC_W:0] sh_v, cl_lo, cl_hi, cl_a, cl_b;

    assign sh_abs = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign sh_mag = sh_abs >> ax_sh;
    assign sh_v   = r_acc[ACC_W-1] ? -$signed({1'b0, sh_mag}) : $signed({1'b0, sh_mag});
    assign cl_lo  = {{(ACC_W-31){ax_lo[31]}}, ax_lo};
    assign cl_hi  = {{(ACC_W-31){ax_hi[31]}}, ax_hi};
    assign cl_a   = (sh_v < cl_lo) ? cl_lo : sh_v;
    assign cl_b   = (cl_a > cl_hi) ? cl_hi : cl_a;

    // bin setup: numerator (v - lo) * GRID, divisor hi - lo + 1
    logic signed [32:0] bs_diff;
    logic [NUM_W-1:0]   bs_num;
    logic [32:0]        bs_den;
    logic               bs_empty;

    assign bs_diff  = {r_v[31], r_v} - {ax_lo[31], ax_lo};
    assign bs_num   = NUM_W'(bs_diff) * NUM_W'(GRID);
    assign bs_den   = 33'({ax_hi[31], ax_hi} - {ax_lo[31], ax_lo} + 33'sd1);
    assign bs_empty = (ax_hi <= ax_lo);

    // one restoring divide step
    logic [NUM_W-1:0] dv_trial;
    logic             dv_ge;
    logic [QW-1:0]    dv_q;

    assign dv_trial = NUM_W'(r_den) << r_k;
    assign dv_ge    = (r_num >= dv_trial);
    always_comb begin
        dv_q = r_q;
        if (dv_ge) begin
            dv_q[r_k] = 1'b1;
        end
    end

    // resonance class by cross-multiplied percentage thresholds
    logic [31:0]        rs_axl, rs_axh, rs_ayl, rs_ayh, rs_px, rs_py;
    logic [32:0]        rs_emax, rs_e;
    logic [39:0]        rs_eps, rs_lo, rs_hi;
    logic signed [32:0] rs_s;
    logic [1:0]         rs_mag;
    logic signed [2:0]  n_res;

    assign rs_axl  = r_xlo[31] ? 32'(-r_xlo) : 32'(r_xlo);
    assign rs_axh  = r_xhi[31] ? 32'(-r_xhi) : 32'(r_xhi);
    assign rs_ayl  = r_ylo[31] ? 32'(-r_ylo) : 32'(r_ylo);
    assign rs_ayh  = r_yhi[31] ? 32'(-r_yhi) : 32'(r_yhi);
    assign rs_px   = r_px[31] ? 32'(-r_px) : 32'(r_px);
    assign rs_py   = r_py[31] ? 32'(-r_py) : 32'(r_py);
    assign rs_emax = 33'((rs_axl > rs_axh) ? rs_axl : rs_axh)
                   + 33'((rs_ayl > rs_ayh) ? rs_ayl : rs_ayh);
    assign rs_e    = 33'(rs_px) + 33'(rs_py);
    assign rs_eps  = 40'(rs_e) * 40'(PCT_SCALE);
    assign rs_lo   = 40'(rs_emax) * 40'(PCT_LOW);
    assign rs_hi   = 40'(rs_emax) * 40'(PCT_HIGH);
    assign rs_s    = {r_px[31], r_px} + {r_py[31], r_py};

    always_comb begin
        if (rs_emax == 33'd0 || rs_eps < rs_lo) begin
            rs_mag = 2'd0;
        end else if (rs_eps < rs_hi) begin
            rs_mag = 2'd1;
        end else begin
            rs_mag = 2'd2;
        end
        if (rs_s > 33'sd0) begin
            n_res = $signed({1'b0, rs_mag});
        end else if (rs_s < 33'sd0) begin
            n_res = -$signed({1'b0, rs_mag});
        end else begin
            n_res = 3'sd0;
        end
    end

    // cell read-modify-write
    logic        cur_valid;
    logic [31:0] cur_sum, cur_cnt;

    assign cur_valid = r_valid[r_cell];
    assign cur_sum   = cur_valid ? ram_rdata[31:0]  : 32'd0;
    assign cur_cnt   = cur_valid ? ram_rdata[63:32] : 32'd0;
    assign ram_we    = (r_state == S_WR);
    assign ram_wdata = {cur_cnt + 32'd1, cur_sum + {{29{r_res[2]}}, r_res}};

    // cell average: clipped quotient by compares against count and twice count
    logic [32:0]       av_s, av_abs, av_c, av_c2;
    logic [1:0]        av_mag;
    logic signed [2:0] av_res;

    assign av_s   = {cur_sum[31], cur_sum};
    assign av_abs = av_s[32] ? 33'(-av_s) : av_s;
    assign av_c   = {1'b0, cur_cnt};
    assign av_c2  = {cur_cnt, 1'b0};
    always_comb begin
        if (cur_cnt == 32'd0 || av_abs < av_c) begin
            av_mag = 2'd0;
        end else if (av_abs < av_c2) begin
            av_mag = 2'd1;
        end else begin
            av_mag = 2'd2;
        end
        av_res = av_s[32] ? -$signed({1'b0, av_mag}) : $signed({1'b0, av_mag});
    end

    pgrb_ram #(
        .WIDTH (64),
        .DEPTH (NCELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cell),
        .i_wdata (ram_wdata),
        .i_raddr (r_cell),
        .o_rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xw  <= '0;
            r_yw  <= '0;
            r_xsh <= '0;
            r_ysh <= '0;
            r_xlo <= -32'sd32768;
            r_xhi <= 32'sd32767;
            r_ylo <= -32'sd32768;
            r_yhi <= 32'sd32767;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_WEIGHT: r_xw  <= i_cfg_data;
                REG_Y_WEIGHT: r_yw  <= i_cfg_data;
                REG_X_SHIFT:  r_xsh <= i_cfg_data[5:0];
                REG_Y_SHIFT:  r_ysh <= i_cfg_data[5:0];
                REG_X_LOW:    r_xlo <= i_cfg_data[31:0];
                REG_X_HIGH:   r_xhi <= i_cfg_data[31:0];
                REG_Y_LOW:    r_ylo <= i_cfg_data[31:0];
                REG_Y_HIGH:   r_yhi <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // payload registers of the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_id  <= s_axis_tdata[31:0];
                r_acc <= '0;
                r_idx <= '0;
                r_ax  <= 1'b0;
                for (int i = 0; i < VEC_LEN; i++) begin
                    r_elem[i] <= s_axis_tdata[32+16*i +: 16];
                end
                r_cell <= '0;
                r_fcol <= '0;
                r_frow <= '0;
            end
            S_MAC: begin
                r_acc <= n_acc;
                r_idx <= (r_idx == IW'(VEC_LEN - 1)) ? '0 : r_idx + 1'b1;
            end
            S_CLAMP: begin
                r_v <= 32'(cl_b);
                if (r_ax) begin
                    r_py <= 32'(cl_b);
                end else begin
                    r_px <= 32'(cl_b);
                end
            end
            S_BSET: begin
                r_num <= bs_num;
                r_den <= bs_den;
                r_q   <= '0;
                r_k   <= KW'(QW - 1);
                r_acc <= '0;
                if (bs_empty) begin
                    if (r_ax) begin
                        r_by <= '0;
                    end else begin
                        r_bx <= '0;
                    end
                    r_ax <= 1'b1;
                end
            end
            S_DIV: begin
                if (dv_ge) begin
                    r_num <= r_num - dv_trial;
                end
                r_q <= dv_q;
                r_k <= r_k - 1'b1;
                if (r_k == '0) begin
                    if (r_ax) begin
                        r_by <= (dv_q > QW'(GRID - 1)) ? QW'(GRID - 1) : dv_q;
                    end else begin
                        r_bx <= (dv_q > QW'(GRID - 1)) ? QW'(GRID - 1) : dv_q;
                    end
                    r_ax <= 1'b1;
                end
            end
            S_RES: begin
                r_res  <= n_res;
                r_cell <= CW'(32'(r_by) * GRID + 32'(r_bx));
            end
            S_WR: begin
                r_out.kind      <= KIND_STATE;
                r_out.echo_id   <= r_id;
                r_out.cell_col  <= 3'(r_bx);
                r_out.cell_row  <= 3'(r_by);
                r_out.proj_x    <= r_px;
                r_out.proj_y    <= r_py;
                r_out.resonance <= r_res;
                r_out.last      <= 1'b1;
            end
            S_FCALC: begin
                r_out.kind      <= KIND_CELL;
                r_out.echo_id   <= '0;
                r_out.cell_col  <= 3'(r_fcol);
                r_out.cell_row  <= 3'(r_frow);
                r_out.proj_x    <= '0;
                r_out.proj_y    <= '0;
                r_out.resonance <= av_res;
                r_out.last      <= (r_cell == CW'(NCELLS - 1));
            end
            S_FOUT: begin
                if (m_axis_tready) begin
                    r_cell <= r_cell + 1'b1;
                    if (r_fcol == QW'(GRID - 1)) begin
                        r_fcol <= '0;
                        r_frow <= r_frow + 1'b1;
                    end else begin
                        r_fcol <= r_fcol + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // sequencer control
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (s_axis_tuser == OP_FINISH) ? S_FRD : S_MAC;
                end
            end
            S_MAC:   n_state = (r_idx == IW'(VEC_LEN - 1)) ? S_CLAMP : S_MAC;
            S_CLAMP: n_state = S_BSET;
            S_BSET: begin
                if (!bs_empty) begin
                    n_state = S_DIV;
                end else begin
                    n_state = r_ax ? S_RES : S_MAC;
                end
            end
            S_DIV: begin
                if (r_k == '0) begin
                    n_state = r_ax ? S_RES : S_MAC;
                end
            end
            S_RES:   n_state = S_RD;
            S_RD:    n_state = S_WR;
            S_WR:    n_state = S_OUT;
            S_OUT:   n_state = m_axis_tready ? S_IDLE : S_OUT;
            S_FRD:   n_state = S_FCALC;
            S_FCALC: n_state = S_FOUT;
            S_FOUT: begin
                if (m_axis_tready) begin
                    n_state = (r_cell == CW'(NCELLS - 1)) ? S_IDLE : S_FRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_WR) begin
                r_valid[r_cell] <= 1'b1;
                r_ovalid        <= 1'b1;
            end else if (r_state == S_FCALC) begin
                r_valid[r_cell] <= 1'b0;
                r_ovalid        <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ports
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {7'd0, r_out.resonance, r_out.proj_y, r_out.proj_x,
                            r_out.cell_row, r_out.cell_col, r_out.echo_id};

    // checks
    a_busy_when_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result is pending");

    a_bins_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.cell_col < 3'(GRID) || GRID > 7)
                          && (r_out.cell_row < 3'(GRID) || GRID > 7))
        else $error("bin index beyond grid");

    a_last_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_CELL && m_axis_tlast)
            |-> r_cell == CW'(NCELLS - 1))
        else $error("finish ended on wrong cell");

    a_store_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_CELL && m_axis_tlast)
            |=> r_valid == '0)
        else $error("store not cleared after finish");

endmodule
